/* rtl/hcbd_pkg.sv */
package hcbd_pkg;

  // Configuration port geometry: one 32-bit register at byte address 0.
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [CFG_AW-1:0] REG_CHUNKED_ENABLE = 3'd0;
  localparam logic              CHUNKED_ENABLE_RST = 1'b1;

  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;

  // Number of bytes that close each chunk (CR LF).
  localparam logic [1:0] TRAILER_LEN = 2'd2;

  typedef enum logic [5:0] {
    PH_LEAD   = 6'b000001,
    PH_DIGITS = 6'b000010,
    PH_REST   = 6'b000100,
    PH_DATA   = 6'b001000,
    PH_TRAIL  = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t r;
    r.ok    = 1'b1;
    r.value = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r.value = 4'(c - 8'h30);
    end else if (c inside {[8'h61:8'h66]}) begin
      r.value = 4'(c - 8'h61 + 8'd10);
    end else if (c inside {[8'h41:8'h46]}) begin
      r.value = 4'(c - 8'h41 + 8'd10);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

/* rtl/hcbd_if.sv */
interface hcbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] body_byte;
  logic       new_body;

  modport source (output valid, output body_byte, output new_body, input ready);
  modport sink   (input valid, input body_byte, input new_body, output ready);
endinterface

interface hcbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       body_finished;

  modport source (output valid, output out_byte, output out_valid, output body_finished,
                  input ready);
  modport sink   (input valid, input out_byte, input out_valid, input body_finished,
                  output ready);
endinterface

/* rtl/http_chunked_body_decoder_top.sv */
// Chunked transfer decoder for an HTTP response body.
//
// in_ch carries one raw body byte per word, with new_body marking the first
// byte of a fresh body. out_ch returns exactly one word per input word:
// out_valid says whether the byte is payload (out_byte is zero otherwise) and
// body_finished is set once a zero-size chunk line has been closed.
// The APB-style cfg_ port holds chunked_enable at address 0; clearing it
// passes every byte straight through and holds the decoder state unless new_body restarts it.
//
// The byte is captured in an input register at acceptance and decoded by a
// single pass of logic into the result register, which it enters once that
// register is not stalled. Throughput is one word per cycle while out_ch is
// not stalled, set by that single decode stage; the phase, size and count
// registers are updated in the same cycle that the result is written.
//
// The input register and the result register form two slots, so a word is
// still accepted while a finished result waits on a stalled receiver; once
// both slots are full in_ch.ready drops until out_ch is drained.
// Synchronous reset empties both slots, returns the decoder to the start of
// a size line and sets chunked_enable to one.
module http_chunked_body_decoder_top #(
  parameter int SIZE_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  hcbd_in_if.sink                    in_ch,
  hcbd_out_if.source                 out_ch,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [hcbd_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [hcbd_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [hcbd_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import hcbd_pkg::*;

  localparam logic [SIZE_BITS-1:0] SIZE_ALL_ONES = {SIZE_BITS{1'b1}};

  // Configuration register. Only the index bit is decoded, so any byte
  // address inside the first word selects chunked_enable.
  logic chunked_enable_r;
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunked_enable_r <= CHUNKED_ENABLE_RST;
    end else if (cfg_wr && (cfg_paddr[CFG_AW-1] == REG_CHUNKED_ENABLE[CFG_AW-1])) begin
      chunked_enable_r <= cfg_pwdata[0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[CFG_AW-1] == REG_CHUNKED_ENABLE[CFG_AW-1]) begin
      cfg_prdata[0] = chunked_enable_r;
    end
  end

  // Two-slot flow control: input register feeding the result register.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_new_r;
  logic       out_valid_r;
  logic       out_stall;
  logic       s1_advance;
  logic       in_take;

  assign out_stall   = out_valid_r && !out_ch.ready;
  assign s1_advance  = s1_valid_r && !out_stall;
  assign in_ch.ready = !s1_valid_r || s1_advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_ch.body_byte;
      s1_new_r  <= in_ch.new_body;
    end
  end

  // Decoder state.
  phase_t               phase_r, phase_nxt;
  logic [SIZE_BITS-1:0] chunk_size_r, chunk_size_nxt;
  logic [SIZE_BITS-1:0] bytes_left_r, bytes_left_nxt;
  logic                 cr_seen_r, cr_seen_nxt;

  logic [7:0]           res_byte_nxt;
  logic                 res_valid_nxt;
  logic                 res_finished_nxt;

  hex_digit_t           hex;
  logic                 is_blank;
  logic                 line_end;
  logic [SIZE_BITS-1:0] count_dec;

  assign hex      = hex_decode(s1_byte_r);
  assign is_blank = (s1_byte_r == CH_SP) || (s1_byte_r == CH_TAB);

  always_comb begin
    phase_nxt        = phase_r;
    chunk_size_nxt   = chunk_size_r;
    bytes_left_nxt   = bytes_left_r;
    cr_seen_nxt      = cr_seen_r;
    res_valid_nxt    = 1'b0;
    line_end         = 1'b0;
    count_dec        = '0;

    // A new body restarts the decoder before its first byte is looked at.
    if (s1_new_r) begin
      phase_nxt      = PH_LEAD;
      chunk_size_nxt = '0;
      bytes_left_nxt = '0;
      cr_seen_nxt    = 1'b0;
    end

    if (chunked_enable_r) begin
      case (phase_nxt)
        PH_LEAD, PH_DIGITS: begin
          if ((phase_nxt == PH_LEAD) && is_blank) begin
            phase_nxt = PH_LEAD;
          end else if (hex.ok) begin
            // Saturate once another digit would overflow the size field.
            if (chunk_size_nxt[SIZE_BITS-1 -: 4] != 4'd0) begin
              chunk_size_nxt = SIZE_ALL_ONES;
            end else begin
              chunk_size_nxt = {chunk_size_nxt[SIZE_BITS-5:0], hex.value};
            end
            phase_nxt = PH_DIGITS;
          end else begin
            // First non-digit ends the number; it can never complete CR LF.
            cr_seen_nxt = (s1_byte_r == CH_CR);
            phase_nxt   = PH_REST;
          end
        end
        PH_REST: begin
          line_end = (s1_byte_r == CH_LF) && cr_seen_nxt;
          if (line_end) begin
            cr_seen_nxt = 1'b0;
            if (chunk_size_nxt == '0) begin
              phase_nxt = PH_DONE;
            end else begin
              bytes_left_nxt = chunk_size_nxt;
              phase_nxt      = PH_DATA;
            end
          end else begin
            cr_seen_nxt = (s1_byte_r == CH_CR);
          end
        end
        PH_DATA: begin
          res_valid_nxt = 1'b1;
          count_dec     = (bytes_left_nxt != '0) ? bytes_left_nxt - 1'b1 : bytes_left_nxt;
          if (count_dec == '0) begin
            bytes_left_nxt = SIZE_BITS'(TRAILER_LEN);
            phase_nxt      = PH_TRAIL;
          end else begin
            bytes_left_nxt = count_dec;
          end
        end
        PH_TRAIL: begin
          count_dec      = (bytes_left_nxt != '0) ? bytes_left_nxt - 1'b1 : bytes_left_nxt;
          bytes_left_nxt = count_dec;
          if (count_dec == '0) begin
            chunk_size_nxt = '0;
            cr_seen_nxt    = 1'b0;
            phase_nxt      = PH_LEAD;
          end
        end
        PH_DONE: begin
          phase_nxt = PH_DONE;
        end
        default: begin
          phase_nxt      = PH_LEAD;
          chunk_size_nxt = '0;
          bytes_left_nxt = '0;
          cr_seen_nxt    = 1'b0;
        end
      endcase
      res_byte_nxt     = res_valid_nxt ? s1_byte_r : 8'h00;
      res_finished_nxt = (phase_nxt == PH_DONE);
    end else begin
      // Pass-through: every byte is payload and the framing state is held, unless new_body restarted it above.
      res_valid_nxt    = 1'b1;
      res_byte_nxt     = s1_byte_r;
      res_finished_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_LEAD;
      chunk_size_r <= '0;
      bytes_left_r <= '0;
      cr_seen_r    <= 1'b0;
    end else if (s1_advance) begin
      phase_r      <= phase_nxt;
      chunk_size_r <= chunk_size_nxt;
      bytes_left_r <= bytes_left_nxt;
      cr_seen_r    <= cr_seen_nxt;
    end
  end

  // Result register.
  logic [7:0] out_byte_r;
  logic       out_is_payload_r;
  logic       out_finished_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_stall) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_byte_r       <= res_byte_nxt;
      out_is_payload_r <= res_valid_nxt;
      out_finished_r   <= res_finished_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_byte      = out_byte_r;
  assign out_ch.out_valid     = out_is_payload_r;
  assign out_ch.body_finished = out_finished_r;

endmodule

/* rtl/hcbd_checker.sv */
module hcbd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_is_payload,
  input logic       out_body_finished
);

  // Nothing is offered in the cycle after reset.
  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

  // Framing bytes are reported as zero.
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_payload |-> out_byte == 8'h00)
    else $error("dropped byte carries a non-zero value");

  // A finished body never passes payload.
  a_finished_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_payload && out_body_finished))
    else $error("payload reported after end of body");

  // With nothing offered and no word just accepted, input must be accepted.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !$past(in_valid && in_ready) |-> in_ready)
    else $error("input stalled with both slots empty");

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
      $stable(out_is_payload) && $stable(out_body_finished))
    else $error("stalled result changed");

endmodule

bind http_chunked_body_decoder_top hcbd_checker u_hcbd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_byte          (out_ch.out_byte),
  .out_is_payload    (out_ch.out_valid),
  .out_body_finished (out_ch.body_finished)
);

/* bench/chunk_decode_checker.sv */
module chunk_decode_checker #(
  parameter int SIZE_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  hcbd_in_if                          in_ch,
  hcbd_out_if                         out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic                        cfg_pready,
  input  logic [hcbd_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [hcbd_pkg::CFG_DW-1:0] cfg_pwdata,
  output int                          mismatches,
  output int                          outstanding
);
  import hcbd_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       payload;
    logic       finished;
  } decoded_t;

  decoded_t             awaited_words[$];
  logic                 decode_on;
  phase_t               phase;
  logic [SIZE_BITS-1:0] size_acc;
  logic [SIZE_BITS-1:0] remaining;
  logic                 cr_seen;
  int                   fails;

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic void restart_decoder();
    phase     = PH_LEAD;
    size_acc  = '0;
    remaining = '0;
    cr_seen   = 1'b0;
  endfunction

  // Everything after the number on a size line; only CR directly followed
  // by LF closes the line.
  function automatic void size_line_tail(input logic [7:0] b);
    if (b == CH_LF && cr_seen) begin
      cr_seen = 1'b0;
      if (size_acc == '0) begin
        phase = PH_DONE;
      end else begin
        remaining = size_acc;
        phase     = PH_DATA;
      end
    end else begin
      cr_seen = (b == CH_CR);
      phase   = PH_REST;
    end
  endfunction

  function automatic decoded_t decode_byte(input logic [7:0] b, input logic fresh);
    decoded_t r;
    int       digit;
    logic     keep;
    keep = 1'b0;
    if (fresh) restart_decoder();
    if (!decode_on) begin
      r.data     = b;
      r.payload  = 1'b1;
      r.finished = 1'b0;
      return r;
    end
    case (phase)
      PH_LEAD, PH_DIGITS: begin
        if (!(phase == PH_LEAD && (b == CH_SP || b == CH_TAB))) begin
          digit = hex_digit(b);
          if (digit >= 0) begin
            if (size_acc[SIZE_BITS-1 -: 4] != 4'd0) begin
              size_acc = '1;
            end else begin
              size_acc = {size_acc[SIZE_BITS-5:0], digit[3:0]};
            end
            phase = PH_DIGITS;
          end else begin
            cr_seen = 1'b0;
            size_line_tail(b);
          end
        end
      end
      PH_REST: size_line_tail(b);
      PH_DATA: begin
        keep = 1'b1;
        if (remaining != '0) remaining--;
        if (remaining == '0) begin
          remaining = SIZE_BITS'(TRAILER_LEN);
          phase     = PH_TRAIL;
        end
      end
      PH_TRAIL: begin
        if (remaining != '0) remaining--;
        if (remaining == '0) begin
          size_acc = '0;
          cr_seen  = 1'b0;
          phase    = PH_LEAD;
        end
      end
      PH_DONE: ;
      default: restart_decoder();
    endcase
    r.data     = keep ? b : 8'h00;
    r.payload  = keep;
    r.finished = (phase == PH_DONE);
    return r;
  endfunction

  always @(posedge clk) begin
    decoded_t want;
    if (!rst_n) begin
      awaited_words.delete();
      decode_on = CHUNKED_ENABLE_RST;
      restart_decoder();
    end else begin
      // Results leave only after their byte has passed the input register, so the oldest
      // expectation is matched before this edge's byte is predicted.
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_words.size() == 0) begin
          $error("result word with nothing expected: out_byte %02h", out_ch.out_byte);
          fails++;
        end else begin
          want = awaited_words.pop_front();
          if (out_ch.out_byte !== want.data) begin
            $error("out_byte: expected %02h, got %02h", want.data, out_ch.out_byte);
            fails++;
          end
          if (out_ch.out_valid !== want.payload) begin
            $error("out_valid: expected %0b, got %0b", want.payload, out_ch.out_valid);
            fails++;
          end
          if (out_ch.body_finished !== want.finished) begin
            $error("body_finished: expected %0b, got %0b", want.finished,
                   out_ch.body_finished);
            fails++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        awaited_words.push_back(decode_byte(in_ch.body_byte, in_ch.new_body));
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == REG_CHUNKED_ENABLE) begin
        decode_on = cfg_pwdata[0];
      end
    end
    outstanding <= awaited_words.size();
    mismatches  <= fails;
  end

endmodule

/* bench/testbench.sv */
module testbench;
  import hcbd_pkg::*;

  // Cycles for which the receiver refuses results when the stimulus asks
  // for back-pressure; far longer than the two word slots of the block.
  localparam int LONG_HOLD = 80;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  hcbd_in_if  in_ch();
  hcbd_out_if out_ch();

  int   mismatches;
  int   outstanding;
  int   words_sent;
  int   burst_left;
  int   hold_requests;
  logic gaps_on;
  logic opening;

  http_chunked_body_decoder_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  chunk_decode_checker checker_inst (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_pready  (cfg_pready),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  // A watchdog for the whole run, with a wide margin over an honest run.
  initial begin
    #3000000;
    $display("testbench NOT OK");
    $finish;
  end

  // Receiver. It changes its stalling habit every so often: always ready,
  // random refusals, or a fixed three-in-five pattern. When the stimulus
  // raises a hold request it refuses every word for a long stretch.
  initial begin
    int cyc;
    int served;
    int rx_mode;
    cyc     = 0;
    served  = 0;
    rx_mode = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 150 == 0) rx_mode = $urandom_range(0, 2);
      if (hold_requests != served) begin
        served++;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        case (rx_mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
          default: out_ch.ready <= (cyc % 5 < 3);
        endcase
      end
    end
  end

  function automatic logic [7:0] hex_char(input logic [3:0] v, input logic upper);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return (upper ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
  endfunction

  // Offers one word and returns at the edge that accepts it. The sender
  // works in bursts; between bursts it may drop valid before the next word.
  // valid is left high after acceptance, so back-to-back words never see
  // it lowered and raised within one step.
  task automatic send_word(input logic [7:0] b);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on && $urandom_range(0, 1) == 1) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.body_byte <= b;
    in_ch.new_body  <= opening;
    opening = 1'b0;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_word(s[i]);
  endtask

  task automatic send_crlf();
    send_word(CH_CR);
    send_word(CH_LF);
  endtask

  // Lets every outstanding result drain; the block is idle afterwards.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Two-phase register write: setup, then access. The register takes the
  // value at the edge where the access phase meets pready.
  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // A size line: optional blanks, the hex size with optional leading zeros
  // and mixed case, sometimes an extension or a stray CR or LF, then CR LF.
  task automatic send_size_line(input int unsigned size);
    int unsigned digits;
    int          i;
    repeat ($urandom_range(0, 2)) send_word($urandom_range(0, 1) ? CH_SP : CH_TAB);
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0) send_word("0");
    digits = 1;
    while (digits < 8 && (size >> (4 * digits)) != 0) digits++;
    for (i = int'(digits) - 1; i >= 0; i--) begin
      send_word(hex_char(4'(size >> (4 * i)), 1'($urandom_range(0, 1))));
    end
    case ($urandom_range(0, 5))
      0: begin
        // Chunk extension made only of letters beyond the hex range.
        send_word(";");
        repeat ($urandom_range(1, 3)) send_word(8'($urandom_range(8'h67, 8'h7A)));
      end
      1: begin
        // A CR that is not followed by LF must not close the line.
        send_word(" ");
        send_word(CH_CR);
        send_word("q");
      end
      2: send_word(CH_LF);
      default: ;
    endcase
    send_crlf();
  endtask

  // A well-formed body with random content: a few chunks, mostly small,
  // now and then a longer one, and once in a while a trailer that is not
  // CR LF. A zero-size line closes it, sometimes followed by stray bytes
  // that must be dropped.
  task automatic send_chunked_body();
    int unsigned size;
    opening = 1'b1;
    gaps_on = ($urandom_range(0, 3) != 0);
    repeat ($urandom_range(0, 4)) begin
      size = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 300) : $urandom_range(1, 16);
      send_size_line(size);
      repeat (size) send_word(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 5) == 0) begin
        send_word(8'($urandom_range(0, 255)));
        send_word(8'($urandom_range(0, 255)));
      end else begin
        send_crlf();
      end
    end
    send_size_line(0);
    repeat ($urandom_range(0, 3)) send_word(8'($urandom_range(0, 255)));
  endtask

  // Broken framing: bytes biased towards CR, LF, hex digits and signs, with
  // new_body raised at random.
  task automatic send_noise();
    logic [7:0] b;
    repeat ($urandom_range(3, 20)) begin
      case ($urandom_range(0, 5))
        0:       b = CH_CR;
        1:       b = CH_LF;
        2:       b = hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
        3:       b = "-";
        default: b = 8'($urandom_range(0, 255));
      endcase
      opening = ($urandom_range(0, 7) == 0);
      send_word(b);
    end
  endtask

  task automatic send_bodies_until(input int target);
    while (words_sent < target) begin
      if ($urandom_range(0, 7) == 0) send_noise();
      else send_chunked_body();
    end
  endtask

  // Random bytes for pass-through mode. new_body may be kept low so that
  // the held decoder state survives for the next decoding phase.
  task automatic send_raw(input int count, input logic allow_fresh);
    gaps_on = 1'b1;
    repeat (count) begin
      opening = allow_fresh && ($urandom_range(0, 3) == 0);
      send_word(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int guard;
    rst_n           <= 1'b0;
    cfg_psel        <= 1'b0;
    cfg_penable     <= 1'b0;
    cfg_pwrite      <= 1'b0;
    cfg_paddr       <= '0;
    cfg_pwdata      <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.body_byte <= 8'h00;
    in_ch.new_body  <= 1'b0;
    hold_requests   <= 0;
    words_sent = 0;
    burst_left = 0;
    gaps_on    = 1'b1;
    opening    = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    write_reg(REG_CHUNKED_ENABLE, CFG_DW'(1));

    // Directed part. Leading tab, a two-byte chunk carrying the extreme
    // byte values, and a trailer that is not CR LF but is dropped anyway.
    opening = 1'b1;
    send_word(CH_TAB);
    send_text("2");
    send_crlf();
    send_word(8'h00);
    send_word(8'hFF);
    send_text("ZZ");
    // A "0x" prefix ends the number at the x; a lone LF and a CR followed
    // by another CR do not close the line. The size is zero, so the body
    // ends, and the byte after that is dropped.
    send_text("0x");
    send_word(CH_LF);
    send_word(CH_CR);
    send_crlf();
    send_text("7");
    // A sign in place of digits: no number at all counts as size zero.
    opening = 1'b1;
    send_text("-");
    send_crlf();
    // Nine digits overflow the size, which must saturate; one payload byte
    // follows.
    opening = 1'b1;
    send_text("1aBcDeF09");
    send_crlf();
    send_word(8'h5A);
    drain();

    // Pass-through with new_body at random.
    write_reg(REG_CHUNKED_ENABLE, CFG_DW'(0));
    send_raw(120, 1'b1);
    drain();

    // Main decoding phase. Half-way the receiver is told to hold off while
    // the sender keeps offering, so both slots fill and the input stalls.
    write_reg(REG_CHUNKED_ENABLE, CFG_DW'(1));
    send_bodies_until(350);
    hold_requests <= hold_requests + 1;
    send_bodies_until(520);
    // Stop in the middle of a five-byte chunk, with three bytes to go.
    opening = 1'b1;
    send_text("5");
    send_crlf();
    send_text("ab");
    drain();

    // Pass-through without new_body: the decoder state must be held.
    write_reg(REG_CHUNKED_ENABLE, CFG_DW'(0));
    send_raw(60, 1'b0);
    drain();

    // Decoding resumes where it stopped: the rest of the chunk, its
    // trailer and the end of the body, then more random bodies.
    write_reg(REG_CHUNKED_ENABLE, CFG_DW'(1));
    send_text("cde");
    send_crlf();
    send_text("0");
    send_crlf();
    send_bodies_until(760);
    hold_requests <= hold_requests + 1;
    send_bodies_until(930);

    // Wait for the last results, then keep the clock running in case the block
    // still sends something it should not.
    in_ch.valid <= 1'b0;
    guard = 0;
    do begin
      @(posedge clk);
      guard++;
    end while (outstanding != 0 && guard < 4000);
    repeat (8) @(posedge clk);
    if (outstanding != 0) $error("%0d result words never arrived", outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
